### src/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned MAX_POSITIONS_DEF    = 1024;
  localparam int unsigned MAX_VERSIONS_DEF     = 4096;
  localparam int unsigned NODE_STORE_DEPTH_DEF = 65536;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_SEAL   = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_VERSION = 3'd1;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NOT_SEALED = 3'd4;

  localparam logic [10:0] SIZE_RESET = 11'd1024;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_BLD   = 7'b0000100,
    S_LEAF  = 7'b0001000,
    S_WROOT = 7'b0010000,
    S_WNODE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic accept;
    logic decode;
    logic bld;
    logic leaf;
    logic wroot;
    logic wnode;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic go_build;
    logic go_walk;
    logic bld_leaf;
    logic stack_empty;
    logic walk_leaf;
    logic out_free;
  } sts_t;

endpackage

### src/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/pst_ctrl.sv
// ----------------------------------------------------------------------------
// pst_ctrl
// sequencing state machine for load, seal build and tree walks
// ----------------------------------------------------------------------------
module pst_ctrl import pst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o.decode = 1'b1;
        if (sts_i.go_build) state_d = S_BLD;
        else if (sts_i.go_walk) state_d = S_WROOT;
        else state_d = S_DONE;
      end
      S_BLD: begin
        cmd_o.bld = 1'b1;
        if (sts_i.bld_leaf) state_d = S_LEAF;
      end
      S_LEAF: begin
        cmd_o.leaf = 1'b1;
        state_d = sts_i.stack_empty ? S_DONE : S_BLD;
      end
      S_WROOT: begin
        cmd_o.wroot = 1'b1;
        state_d = S_WNODE;
      end
      S_WNODE: begin
        cmd_o.wnode = 1'b1;
        if (sts_i.walk_leaf) state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = sts_i.out_free;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/pst_dp.sv
// ----------------------------------------------------------------------------
// pst_dp
// datapath: item registers, checks, build stack, tree walk and node memories
// ----------------------------------------------------------------------------
module pst_dp import pst_pkg::*; #(
  parameter int unsigned MAX_POSITIONS    = MAX_POSITIONS_DEF,
  parameter int unsigned MAX_VERSIONS     = MAX_VERSIONS_DEF,
  parameter int unsigned NODE_STORE_DEPTH = NODE_STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic [1:0]  mode_i,
  input  logic [11:0] version_i,
  input  logic [10:0] index_i,
  input  logic [31:0] new_value_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] read_value_o,
  output logic [11:0] made_version_o,
  output logic [2:0]  status_o,
  input  cmd_t        cmd_i,
  output sts_t        sts_o
);

  localparam int unsigned PW   = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned IAW  = $clog2(MAX_POSITIONS);
  localparam int unsigned NW   = $clog2(NODE_STORE_DEPTH);
  localparam int unsigned NNW  = NW + 1;
  localparam int unsigned NDW  = 32 + 2 * NW;
  localparam int unsigned VW   = $clog2(MAX_VERSIONS);
  localparam int unsigned VCW  = VW + 1;
  localparam int unsigned SD   = $clog2(MAX_POSITIONS) + 1;
  localparam int unsigned SPW  = $clog2(SD + 1);
  localparam int unsigned SIW  = $clog2(SD);

  // configuration and persistent state
  logic [10:0]    size_q;
  logic [PW-1:0]  tree_size_q, tree_size_d;
  logic [NNW-1:0] next_node_q, next_node_d;
  logic [VCW-1:0] vcount_q, vcount_d;
  logic           sealed_q, sealed_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic           out_valid_q;

  // item and walk registers
  logic [1:0]     mode_q;
  logic [11:0]    ver_q;
  logic [10:0]    pos_q;
  logic [31:0]    val_q;
  logic [PW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [NW-1:0]  k_q, k_d;
  logic [NNW-1:0] nk_q, nk_d;
  logic [NW-1:0]  root_new_q, root_new_d;
  logic [NW-1:0]  old_root_q, old_root_d;
  logic [2:0]     res_st_q, res_st_d;
  logic [31:0]    res_rd_q, res_rd_d;
  logic [11:0]    res_made_q, res_made_d;
  logic [31:0]    out_rd_q;
  logic [11:0]    out_made_q;
  logic [2:0]     out_st_q;

  // build stack of pending right subtrees
  logic [PW-1:0]  stk_lo_q [SD];
  logic [PW-1:0]  stk_hi_q [SD];
  logic [NW-1:0]  stk_k_q  [SD];
  logic           push;
  logic [SIW-1:0] top_idx;

  // memory ports
  logic           iv_we;
  logic [IAW-1:0] iv_waddr, iv_raddr;
  logic [31:0]    iv_rdata;
  logic           nd_we;
  logic [NW-1:0]  nd_waddr, nd_raddr;
  logic [NDW-1:0] nd_wdata, nd_rdata;
  logic           rt_we;
  logic [VW-1:0]  rt_waddr, rt_raddr;
  logic [NW-1:0]  rt_wdata, rt_rdata;

  logic [PW-1:0]  eff;
  logic [PW:0]    sum;
  logic [PW-1:0]  mid;
  logic [2:0]     dec_st;
  logic           at_leaf;
  logic           go_left;
  logic [NNW-1:0] rk;
  logic [31:0]    nv;
  logic [NW-1:0]  nl, nr, nk1;
  logic           nk_ovf;

  assign nv     = nd_rdata[NDW-1 -: 32];
  assign nl     = nd_rdata[2*NW-1 -: NW];
  assign nr     = nd_rdata[NW-1:0];
  assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = sum[PW:1];
  assign at_leaf = (lo_q == hi_q);
  assign go_left = ({{(PW > 11 ? PW - 11 : 0){1'b0}}, pos_q} <= mid);
  assign rk     = NNW'(k_q) + NNW'({NNW'(mid - lo_q) + NNW'(1)} << 1);
  assign nk1    = NW'(nk_q + NNW'(1));
  assign nk_ovf = (32'(nk_q) >= NODE_STORE_DEPTH);
  assign top_idx = SIW'(sp_q - SPW'(1));

  always_comb begin
    if (size_q == 11'd0) eff = PW'(1);
    else if (32'(size_q) > MAX_POSITIONS) eff = PW'(MAX_POSITIONS);
    else eff = PW'(size_q);
  end

  always_comb begin
    dec_st = ST_OK;
    case (mode_q)
      MODE_LOAD: begin
        if (pos_q == 11'd0 || 32'(pos_q) > 32'(eff)) dec_st = ST_BAD_INDEX;
      end
      MODE_SEAL: begin
        if (2 * 32'(eff) - 1 > NODE_STORE_DEPTH - 1) dec_st = ST_FULL;
      end
      default: begin
        if (!sealed_q) dec_st = ST_NOT_SEALED;
        else if (32'(ver_q) >= 32'(vcount_q)) dec_st = ST_BAD_VERSION;
        else if (pos_q == 11'd0 || 32'(pos_q) > 32'(tree_size_q)) dec_st = ST_BAD_INDEX;
        else if (32'(vcount_q) >= MAX_VERSIONS) dec_st = ST_FULL;
      end
    endcase
  end

  assign sts_o.go_build    = (mode_q == MODE_SEAL) && (dec_st == ST_OK);
  assign sts_o.go_walk     = mode_q[1] && (dec_st == ST_OK);
  assign sts_o.bld_leaf    = at_leaf;
  assign sts_o.stack_empty = (sp_q == '0);
  assign sts_o.walk_leaf   = at_leaf;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    tree_size_d = tree_size_q;
    next_node_d = next_node_q;
    vcount_d    = vcount_q;
    sealed_d    = sealed_q;
    sp_d        = sp_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    nk_d        = nk_q;
    root_new_d  = root_new_q;
    old_root_d  = old_root_q;
    res_st_d    = res_st_q;
    res_rd_d    = res_rd_q;
    res_made_d  = res_made_q;
    push        = 1'b0;
    iv_we       = 1'b0;
    iv_waddr    = IAW'(pos_q - 11'd1);
    iv_raddr    = IAW'(lo_q - PW'(1));
    nd_we       = 1'b0;
    nd_waddr    = k_q;
    nd_wdata    = {32'd0, NW'(k_q + NW'(1)), NW'(rk)};
    nd_raddr    = go_left ? nl : nr;
    rt_we       = 1'b0;
    rt_waddr    = VW'(vcount_q);
    rt_wdata    = root_new_q;
    rt_raddr    = VW'(ver_q);

    if (cmd_i.decode) begin
      res_st_d   = dec_st;
      res_rd_d   = '0;
      res_made_d = '0;
      iv_we      = (mode_q == MODE_LOAD) && (dec_st == ST_OK);
      lo_d       = PW'(1);
      if (mode_q == MODE_SEAL) begin
        hi_d = eff;
        k_d  = NW'(1);
        sp_d = '0;
        if (dec_st == ST_OK) tree_size_d = eff;
      end else begin
        hi_d = tree_size_q;
      end
      nk_d       = next_node_q;
      root_new_d = NW'(next_node_q);
    end

    if (cmd_i.bld && !at_leaf) begin
      nd_we = 1'b1;
      push  = 1'b1;
      sp_d  = sp_q + SPW'(1);
      hi_d  = mid;
      k_d   = k_q + NW'(1);
    end

    if (cmd_i.leaf) begin
      nd_we    = 1'b1;
      nd_wdata = {iv_rdata, {(2*NW){1'b0}}};
      if (sp_q == '0) begin
        next_node_d = NNW'(k_q) + NNW'(1);
        vcount_d    = VCW'(1);
        sealed_d    = 1'b1;
        rt_we       = 1'b1;
        rt_waddr    = '0;
        rt_wdata    = NW'(1);
      end else begin
        sp_d = sp_q - SPW'(1);
        lo_d = stk_lo_q[top_idx];
        hi_d = stk_hi_q[top_idx];
        k_d  = stk_k_q[top_idx];
      end
    end

    if (cmd_i.wroot) begin
      nd_raddr   = rt_rdata;
      old_root_d = rt_rdata;
    end

    if (cmd_i.wnode) begin
      nd_waddr = NW'(nk_q);
      if (at_leaf) begin
        if (mode_q == MODE_UPDATE) begin
          if (nk_ovf) begin
            res_st_d = ST_FULL;
          end else begin
            nd_we       = 1'b1;
            nd_wdata    = {val_q, {(2*NW){1'b0}}};
            next_node_d = nk_q + NNW'(1);
            rt_we       = 1'b1;
            res_made_d  = 12'(vcount_q);
            vcount_d    = vcount_q + VCW'(1);
          end
        end else begin
          res_rd_d   = nv;
          rt_we      = 1'b1;
          rt_wdata   = old_root_q;
          res_made_d = 12'(vcount_q);
          vcount_d   = vcount_q + VCW'(1);
        end
      end else begin
        nd_we    = (mode_q == MODE_UPDATE) && !nk_ovf;
        nd_wdata = go_left ? {nv, nk1, nr} : {nv, nl, nk1};
        nk_d     = nk_q + NNW'(1);
        if (go_left) hi_d = mid;
        else lo_d = mid + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      tree_size_q <= PW'(1);
      next_node_q <= NNW'(1);
      vcount_q    <= '0;
      sealed_q    <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) size_q <= cfg_wdata_i;
      tree_size_q <= tree_size_d;
      next_node_q <= next_node_d;
      vcount_q    <= vcount_d;
      sealed_q    <= sealed_d;
      sp_q        <= sp_d;
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= mode_i;
      ver_q  <= version_i;
      pos_q  <= index_i;
      val_q  <= new_value_i;
    end
    if (push) begin
      stk_lo_q[SIW'(sp_q)] <= mid + PW'(1);
      stk_hi_q[SIW'(sp_q)] <= hi_q;
      stk_k_q[SIW'(sp_q)]  <= NW'(rk);
    end
    if (cmd_i.finish) begin
      out_rd_q   <= res_rd_q;
      out_made_q <= res_made_q;
      out_st_q   <= res_st_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    k_q        <= k_d;
    nk_q       <= nk_d;
    root_new_q <= root_new_d;
    old_root_q <= old_root_d;
    res_st_q   <= res_st_d;
    res_rd_q   <= res_rd_d;
    res_made_q <= res_made_d;
  end

  pst_ram #(.WIDTH(32), .DEPTH(MAX_POSITIONS)) u_init_ram (
    .clk_i   (clk_i),
    .we_i    (iv_we),
    .waddr_i (iv_waddr),
    .wdata_i (val_q),
    .raddr_i (iv_raddr),
    .rdata_o (iv_rdata)
  );

  pst_ram #(.WIDTH(NDW), .DEPTH(NODE_STORE_DEPTH)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (nd_we),
    .waddr_i (nd_waddr),
    .wdata_i (nd_wdata),
    .raddr_i (nd_raddr),
    .rdata_o (nd_rdata)
  );

  pst_ram #(.WIDTH(NW), .DEPTH(MAX_VERSIONS)) u_root_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .raddr_i (rt_raddr),
    .rdata_o (rt_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = out_rd_q;
  assign made_version_o = out_made_q;
  assign status_o       = out_st_q;

endmodule

### src/persistent_array_segment_tree.sv
// ----------------------------------------------------------------------------
// persistent_array_segment_tree
// versioned array kept as a path-copying segment tree in a node memory
// ----------------------------------------------------------------------------
// One request is handled at a time; its result sits in an output register, so
// the next request is taken while that result waits. A seal walks the new tree
// in preorder, writing each node into the node memory; at each leaf the initial
// value is read before the leaf is written. An update or query walks from the
// root down to the leaf, with one node memory read per level of the walk; the
// leaf depth is about log2 of the tree size. No clearing pass is needed.
module persistent_array_segment_tree import pst_pkg::*; #(
  parameter int unsigned MAX_POSITIONS    = MAX_POSITIONS_DEF,
  parameter int unsigned MAX_VERSIONS     = MAX_VERSIONS_DEF,
  parameter int unsigned NODE_STORE_DEPTH = NODE_STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,     // size_in_use
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,    // version, index, new_value
  input  logic [1:0]  s_axis_tuser,    // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,    // read_value, made_version
  output logic [2:0]  m_axis_tuser     // status
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] read_value;
  logic [11:0] made_version;

  pst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pst_dp #(
    .MAX_POSITIONS    (MAX_POSITIONS),
    .MAX_VERSIONS     (MAX_VERSIONS),
    .NODE_STORE_DEPTH (NODE_STORE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (s_axis_tuser),
    .version_i      (s_axis_tdata[11:0]),
    .index_i        (s_axis_tdata[22:12]),
    .new_value_i    (s_axis_tdata[54:23]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .read_value_o   (read_value),
    .made_version_o (made_version),
    .status_o       (m_axis_tuser),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  assign m_axis_tdata = {4'd0, made_version, read_value};

endmodule
